@@ hw/rtl/packet_filter_seq_dedup_macros.svh @@
// Assertion macros for the sequence-number duplicate filter
`ifndef PACKET_FILTER_SEQ_DEDUP_MACROS_SVH
`define PACKET_FILTER_SEQ_DEDUP_MACROS_SVH

// same-cycle implication
`define PFSD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfsd check failed");

// next-cycle implication
`define PFSD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfsd check failed");

`endif

@@ hw/rtl/pfsd_pkg.sv @@
// Shared types and constants of the sequence-number duplicate filter
package pfsd_pkg;

   localparam int unsigned HIST_ADDR_W = 10;
   localparam int unsigned SEQ_W       = 16;

   localparam logic [11:0] HEADER_BYTES  = 12'd12;
   localparam logic [11:0] MAX_DATAGRAM  = 12'd2048;
   localparam logic [10:0] MARKER_PLEN   = 11'd4;
   localparam logic [31:0] NODATA_MARKER = 32'h0068_3400;

   typedef enum logic [1:0] {
      VERDICT_ACCEPT = 2'd0,
      VERDICT_SHORT  = 2'd1,
      VERDICT_MARKER = 2'd2,
      VERDICT_DUP    = 2'd3
   } verdict_type;

   typedef struct packed {
      logic                   rd_en;
      logic [HIST_ADDR_W-1:0] rd_addr;
      logic                   wr_en;
      logic [HIST_ADDR_W-1:0] wr_addr;
      logic [SEQ_W-1:0]       wr_data;
      logic [SEQ_W-1:0]       key;
   } hist_ctl_type;

endpackage

@@ hw/rtl/packet_filter_seq_dedup.sv @@
// Top level of the sequence-number duplicate filter: sequencer, ring pointers, result register
//
// One item is taken when start is high and busy is low; its result is shown on rsp_strobe for
// exactly one cycle and cannot be held off. Items that are too short, carry the no-data marker,
// or meet an empty history give their result in the cycle after start and never raise busy.
// Any other item walks the stored sequence numbers through the history RAM, one read and one
// compare per cycle, over at most fill_count entries (HISTORY_DEPTH at most); a duplicate found
// earlier ends the walk early. The single RAM read port sets that pace. There is no clearing
// pass after reset.
`include "packet_filter_seq_dedup_macros.svh"

module packet_filter_seq_dedup import pfsd_pkg::*; #(
   parameter int unsigned HISTORY_DEPTH = 128
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [11:0] req_packet_length,
   input  logic [15:0] req_seq_number,
   input  logic [31:0] req_lead_bytes,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_verdict,
   output logic [10:0] rsp_payload_length
);

   localparam int unsigned AW = $clog2(HISTORY_DEPTH);
   localparam int unsigned CW = $clog2(HISTORY_DEPTH + 1);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_LAST   = 3'b100
   } state_type;

   state_type        state_ff, state_in;
   logic [AW-1:0]    idx_ff, idx_in;
   logic [AW-1:0]    slot_ff, slot_in;
   logic [CW-1:0]    fill_ff, fill_in;
   logic             pend_ff, pend_in;
   logic [SEQ_W-1:0] seq_ff, seq_in;
   logic [10:0]      plen_ff, plen_in;
   logic             strobe_ff, strobe_in;
   verdict_type      verdict_ff, verdict_in;
   logic [10:0]      rsp_plen_ff, rsp_plen_in;

   logic [11:0]      len_clamp;
   logic [11:0]      plen_wide;
   logic             is_short;
   logic             is_marker;
   logic             hit;
   logic [AW-1:0]    slot_next;
   logic [CW-1:0]    fill_next;
   hist_ctl_type     hist_ctl;

   assign len_clamp = (req_packet_length > MAX_DATAGRAM) ? MAX_DATAGRAM : req_packet_length;
   assign plen_wide = len_clamp - HEADER_BYTES;
   assign is_short  = (len_clamp < HEADER_BYTES);
   assign is_marker = (plen_wide[10:0] == MARKER_PLEN) && (req_lead_bytes == NODATA_MARKER);
   assign slot_next = (slot_ff == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_ff + 1'b1;
   assign fill_next = (fill_ff == CW'(HISTORY_DEPTH)) ? fill_ff : fill_ff + 1'b1;

   always_comb begin
      state_in         = state_ff;
      idx_in           = idx_ff;
      slot_in          = slot_ff;
      fill_in          = fill_ff;
      pend_in          = pend_ff;
      seq_in           = seq_ff;
      plen_in          = plen_ff;
      strobe_in        = 1'b0;
      verdict_in       = verdict_ff;
      rsp_plen_in      = rsp_plen_ff;
      hist_ctl.rd_en   = 1'b0;
      hist_ctl.rd_addr = HIST_ADDR_W'(idx_ff);
      hist_ctl.wr_en   = 1'b0;
      hist_ctl.wr_addr = HIST_ADDR_W'(slot_ff);
      hist_ctl.wr_data = seq_ff;
      hist_ctl.key     = seq_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               seq_in  = req_seq_number;
               plen_in = plen_wide[10:0];
               if (is_short) begin
                  strobe_in   = 1'b1;
                  verdict_in  = VERDICT_SHORT;
                  rsp_plen_in = '0;
               end else if (is_marker) begin
                  strobe_in   = 1'b1;
                  verdict_in  = VERDICT_MARKER;
                  rsp_plen_in = plen_wide[10:0];
               end else if (fill_ff == '0) begin
                  hist_ctl.wr_en   = 1'b1;
                  hist_ctl.wr_data = req_seq_number;
                  slot_in          = slot_next;
                  fill_in          = fill_next;
                  strobe_in        = 1'b1;
                  verdict_in       = VERDICT_ACCEPT;
                  rsp_plen_in      = plen_wide[10:0];
               end else begin
                  state_in = ST_SEARCH;
                  idx_in   = '0;
                  pend_in  = 1'b0;
               end
            end
         end
         ST_SEARCH: begin
            hist_ctl.rd_en = 1'b1;
            if (pend_ff && hit) begin
               state_in    = ST_IDLE;
               strobe_in   = 1'b1;
               verdict_in  = VERDICT_DUP;
               rsp_plen_in = plen_ff;
            end else if ((CW'(idx_ff) + 1'b1) == fill_ff) begin
               state_in = ST_LAST;
               pend_in  = 1'b1;
            end else begin
               idx_in  = idx_ff + 1'b1;
               pend_in = 1'b1;
            end
         end
         ST_LAST: begin
            state_in    = ST_IDLE;
            strobe_in   = 1'b1;
            rsp_plen_in = plen_ff;
            if (hit) begin
               verdict_in = VERDICT_DUP;
            end else begin
               verdict_in     = VERDICT_ACCEPT;
               hist_ctl.wr_en = 1'b1;
               slot_in        = slot_next;
               fill_in        = fill_next;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         slot_ff   <= '0;
         fill_ff   <= '0;
         pend_ff   <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         slot_ff   <= slot_in;
         fill_ff   <= fill_in;
         pend_ff   <= pend_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      plen_ff     <= plen_in;
      verdict_ff  <= verdict_in;
      rsp_plen_ff <= rsp_plen_in;
   end

   pfsd_hist #(
      .DEPTH(HISTORY_DEPTH)
   ) u_hist (
      .clock(clock),
      .ctl  (hist_ctl),
      .hit  (hit)
   );

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_verdict        = verdict_ff;
   assign rsp_payload_length = rsp_plen_ff;

   `PFSD_ASSERT_NOW(a_short_zero_len, clock, reset,
      rsp_strobe && (rsp_verdict == VERDICT_SHORT), rsp_payload_length == '0)
   `PFSD_ASSERT_NOW(a_fill_bounded, clock, reset, 1'b1, fill_ff <= CW'(HISTORY_DEPTH))
   `PFSD_ASSERT_NEXT(a_write_means_accept, clock, reset,
      hist_ctl.wr_en, rsp_strobe && (rsp_verdict == VERDICT_ACCEPT))
   `PFSD_ASSERT_NEXT(a_short_fast, clock, reset,
      start && !busy && is_short, rsp_strobe && !busy)

endmodule

@@ hw/rtl/pfsd_hist.sv @@
// History RAM with registered read and the shared sequence-number comparator
module pfsd_hist import pfsd_pkg::*; #(
   parameter int unsigned DEPTH = 128
) (
   input  logic         clock,
   input  hist_ctl_type ctl,
   output logic         hit
);

   localparam int unsigned AW = $clog2(DEPTH);

   logic [SEQ_W-1:0] mem_ff [DEPTH];
   logic [SEQ_W-1:0] rd_q_ff;

   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem_ff[ctl.wr_addr[AW-1:0]] <= ctl.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.rd_en) begin
         rd_q_ff <= mem_ff[ctl.rd_addr[AW-1:0]];
      end
   end

   assign hit = (rd_q_ff == ctl.key);

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the sequence-number duplicate filter
`timescale 1ns / 100ps

module tb_top;
   import pfsd_pkg::*;

   localparam int DEPTH        = 128;
   localparam int RANDOM_ITEMS = 1450;
   localparam int STALL_LIMIT  = 2000;
   localparam int DRAIN_CYCLES = DEPTH + 12;

   typedef struct packed {
      logic [11:0] len;
      logic [15:0] seq;
      logic [31:0] lead;
   } dgram_type;

   typedef struct packed {
      verdict_type verdict;
      logic [10:0] plen;
   } verdict_rec_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [11:0] req_packet_length = '0;
   logic [15:0] req_seq_number = '0;
   logic [31:0] req_lead_bytes = '0;
   logic        rsp_strobe;
   logic [1:0]  rsp_verdict;
   logic [10:0] rsp_payload_length;

   dgram_type       dgram_queue[$];
   verdict_rec_type verdict_due[$];

   logic [15:0] seq_ring[DEPTH];
   int          ring_slot;
   int          ring_fill;
   int          ring_wraps;
   int          verdict_tally[4];

   int  err_count;
   int  sent_count;
   int  stall_count;
   logic take;
   logic steady;

   assign take   = start && !busy;
   assign steady = (sent_count >= 600) && (sent_count < 900);

   packet_filter_seq_dedup #(.HISTORY_DEPTH(DEPTH)) uut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_packet_length  (req_packet_length),
      .req_seq_number     (req_seq_number),
      .req_lead_bytes     (req_lead_bytes),
      .rsp_strobe         (rsp_strobe),
      .rsp_verdict        (rsp_verdict),
      .rsp_payload_length (rsp_payload_length)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   task automatic flag_mismatch(input string msg);
      $display("[%0t] mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   // filter decision and ring update for one accepted datagram
   task automatic predict_filter(input dgram_type d);
      logic [11:0]     len;
      logic            hit;
      verdict_rec_type rec;
      len = (d.len > MAX_DATAGRAM) ? MAX_DATAGRAM : d.len;
      hit = 1'b0;
      if (len < HEADER_BYTES) begin
         rec.verdict = VERDICT_SHORT;
         rec.plen    = '0;
      end else begin
         rec.plen = 11'(len - HEADER_BYTES);
         if (rec.plen == MARKER_PLEN && d.lead == NODATA_MARKER) begin
            rec.verdict = VERDICT_MARKER;
         end else begin
            for (int i = 0; i < ring_fill; i++)
               if (seq_ring[i] == d.seq) hit = 1'b1;
            if (hit) begin
               rec.verdict = VERDICT_DUP;
            end else begin
               rec.verdict = VERDICT_ACCEPT;
               seq_ring[ring_slot] = d.seq;
               ring_slot = (ring_slot + 1) % DEPTH;
               if (ring_slot == 0) ring_wraps++;
               if (ring_fill < DEPTH) ring_fill++;
            end
         end
      end
      verdict_tally[rec.verdict]++;
      verdict_due.push_back(rec);
   endtask

   task automatic queue_dgram(input logic [11:0] len, input logic [15:0] seq,
                              input logic [31:0] lead);
      dgram_queue.push_back('{len: len, seq: seq, lead: lead});
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (!(start && busy)) begin
         if (take) begin
            predict_filter('{len: req_packet_length, seq: req_seq_number,
                             lead: req_lead_bytes});
            sent_count <= sent_count + 1;
         end
         if (dgram_queue.size() != 0 && (steady || $urandom_range(99) >= 26)) begin
            dgram_type d;
            d = dgram_queue.pop_front();
            start             <= 1'b1;
            req_packet_length <= d.len;
            req_seq_number    <= d.seq;
            req_lead_bytes    <= d.lead;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (verdict_due.size() == 0) begin
            flag_mismatch($sformatf("unexpected item, verdict %0d length %0d",
                                    rsp_verdict, rsp_payload_length));
         end else begin
            verdict_rec_type rec;
            rec = verdict_due.pop_front();
            if (rsp_verdict !== rec.verdict)
               flag_mismatch($sformatf("verdict %0d, expected %s", rsp_verdict,
                                       rec.verdict.name()));
            if (rsp_payload_length !== rec.plen)
               flag_mismatch($sformatf("payload length %0d, expected %0d",
                                       rsp_payload_length, rec.plen));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || take || rsp_strobe) begin
         stall_count <= 0;
      end else begin
         stall_count <= stall_count + 1;
         if (stall_count == STALL_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      logic [11:0] len;
      logic [15:0] seq;
      logic [31:0] lead;
      logic [15:0] seq_base;
      int          pick;
      err_count  = 0;
      sent_count = 0;
      ring_slot  = 0;
      ring_fill  = 0;
      ring_wraps = 0;
      foreach (verdict_tally[i]) verdict_tally[i] = 0;

      // directed: lengths at the edges, marker rules, duplicates, no trace of rejects
      queue_dgram(12'd0,    16'h0000, 32'h0000_0000);
      queue_dgram(12'd11,   16'hFFFF, 32'hFFFF_FFFF);
      queue_dgram(12'd12,   16'h0000, 32'h0000_0000);
      queue_dgram(12'd12,   16'h0000, 32'h0000_0000);
      queue_dgram(12'd16,   16'h1234, NODATA_MARKER);
      queue_dgram(12'd16,   16'h1234, NODATA_MARKER ^ 32'h1);
      queue_dgram(12'd16,   16'h1234, NODATA_MARKER);
      queue_dgram(12'd17,   16'h1234, NODATA_MARKER);
      queue_dgram(12'd15,   16'h5555, NODATA_MARKER);
      queue_dgram(12'd4095, 16'hFFFF, 32'hFFFF_FFFF);
      queue_dgram(12'd2048, 16'hFFFF, 32'h0000_0000);
      queue_dgram(12'd2049, 16'hAAAA, 32'h8000_0000);
      queue_dgram(12'd2047, 16'h8000, 32'h5555_5555);
      queue_dgram(12'd11,   16'h0000, 32'h0000_0000);
      queue_dgram(12'd0,    16'h7777, 32'h0000_0000);
      queue_dgram(12'd12,   16'h7777, 32'hAAAA_AAAA);
      queue_dgram(12'd16,   16'h9999, NODATA_MARKER);
      queue_dgram(12'd20,   16'h9999, NODATA_MARKER);
      queue_dgram(12'd13,   16'h0001, 32'h0068_3400);
      queue_dgram(12'd3000, 16'h0001, 32'h0000_0001);
      queue_dgram(12'd1024, 16'h5555, 32'h7FFF_FFFF);

      // random: mostly a pool a little wider than the ring, so hits, misses and eviction mix
      seq_base = 16'($urandom);
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         pick = $urandom_range(99);
         if (pick < 8)       len = 12'($urandom_range(11, 0));
         else if (pick < 20) len = 12'd16;
         else if (pick < 85) len = 12'($urandom_range(200, 12));
         else if (pick < 95) len = 12'($urandom_range(2048, 201));
         else                len = 12'($urandom_range(4095, 2049));
         if ($urandom_range(99) < 25) seq = 16'($urandom);
         else                         seq = seq_base + 16'($urandom_range(159));
         if ((len == 12'd16 && $urandom_range(1)) || $urandom_range(99) < 3)
            lead = NODATA_MARKER;
         else
            lead = $urandom;
         queue_dgram(len, seq, lead);
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      do @(negedge clock);
      while (dgram_queue.size() != 0 || start || verdict_due.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("%0d datagrams: %0d accepted, %0d too short, %0d marker, %0d duplicate",
               sent_count, verdict_tally[VERDICT_ACCEPT], verdict_tally[VERDICT_SHORT],
               verdict_tally[VERDICT_MARKER], verdict_tally[VERDICT_DUP]);
      $display("history ring wrapped %0d times, %0d mismatches", ring_wraps, err_count);
      if (err_count == 0 && verdict_due.size() == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
